// ----- rtl/core/sorted_insert_priority_queue_top_macros.svh -----
// Assertion macros for the sorted priority queue.
// Used by sorted_insert_priority_queue_top; expects clk and rst_n in scope.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef SYNTH
`define SPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spq assertion failed");
`define SPQ_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("spq forbidden condition seen");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ----- rtl/core/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by spq_cell, the top level and the testbench.
package spq_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ----- rtl/core/sorted_insert_priority_queue_top.sv -----
// Top level of the sorted priority queue: command port, occupancy count, cell chain.
// Depends on spq_pkg, spq_cell and sorted_insert_priority_queue_top_macros.svh.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  command  | start / busy       | func, new_value
//  result   | done (1-cycle)     | popped_value, pop_valid, head_value,
//           |                    | entry_count, is_empty, status
//
// Every transaction is taken while start is high; its result strobes on done the next cycle.
// All cells compare against the new value in parallel, so one transaction per cycle.
// busy stays low; a command may be issued in every cycle.
// Reset empties the queue (count to zero); entry contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "sorted_insert_priority_queue_top_macros.svh"
module sorted_insert_priority_queue_top
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic signed [DATA_W-1:0] new_value,
    output logic                     done,
    output logic signed [DATA_W-1:0] popped_value,
    output logic                     pop_valid,
    output logic signed [DATA_W-1:0] head_value,
    output logic [5:0]               entry_count,
    output logic                     is_empty,
    output logic [1:0]               status
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;

    logic signed [DATA_W-1:0] popped_reg;
    logic                     pop_valid_reg;
    logic signed [DATA_W-1:0] head_reg;
    logic [CNT_W-1:0]         count_out_reg;
    status_t                  status_reg;
    status_t                  status_next;

    logic      accept;
    logic      full;
    logic      empty;
    cell_cmd_t cmd;

    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic signed [DATA_W-1:0] cell_value_next [CAPACITY];
    logic                     cell_lt [CAPACITY];

    // every transaction completes in the cycle it is accepted
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);

    assign cmd.ins   = accept && (func == FUNC_INSERT) && !full;
    assign cmd.rem   = accept && (func == FUNC_REMOVE) && !empty;
    assign cmd.value = new_value;

    always_comb
    begin
        count_next  = count_reg;
        status_next = STAT_OK;
        if (cmd.ins)
            count_next = count_reg + 1'b1;
        else if (cmd.rem)
            count_next = count_reg - 1'b1;
        if (accept && (func == FUNC_INSERT) && full)
            status_next = STAT_FULL;
        else if (accept && (func == FUNC_REMOVE) && empty)
            status_next = STAT_EMPTY;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                     left_lt;
            logic signed [DATA_W-1:0] left_value;
            logic signed [DATA_W-1:0] right_value;

            if (i == 0)
            begin : g_first
                // head cell: new value lands here unless this entry stays
                assign left_lt    = 1'b1;
                assign left_value = cell_value[0];
            end
            else
            begin : g_mid
                assign left_lt    = cell_lt[i-1];
                assign left_value = cell_value[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_value = cell_value[i];
            end
            else
            begin : g_inner
                assign right_value = cell_value[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (count_reg > CNT_W'(i)),
                .left_lt     (left_lt),
                .left_value  (left_value),
                .right_value (right_value),
                .lt          (cell_lt[i]),
                .value       (cell_value[i]),
                .value_next  (cell_value_next[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result payload: no reset, qualified by done
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg    <= cmd.rem ? cell_value[0] : '0;
            pop_valid_reg <= cmd.rem;
            head_reg      <= (count_next != '0) ? cell_value_next[0] : '0;
            count_out_reg <= count_next;
            status_reg    <= status_next;
        end
    end

    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign pop_valid    = pop_valid_reg;
    assign head_value   = head_reg;
    assign entry_count  = 6'(count_out_reg);
    assign is_empty     = (count_out_reg == '0);
    assign status       = status_reg;

    `SPQ_ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(CAPACITY))
    `SPQ_ASSERT(a_done_follows, start |=> done)
    `SPQ_ASSERT(a_done_caused, done |-> $past(start))
    `SPQ_ASSERT(a_ins_grows, cmd.ins |=> count_reg == $past(count_reg) + 1'b1)
    `SPQ_ASSERT_NEVER(a_pop_status, done && pop_valid && (status != STAT_OK))

endmodule

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted chain: holds one entry and trades with its neighbors.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic                     occupied,
    input  logic                     left_lt,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] right_value,
    output logic                     lt,
    output logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] value_next
);

    logic signed [DATA_W-1:0] value_reg;

    // Entry stays put on insert when it is strictly smaller than the new value
    assign lt    = occupied && (value_reg < cmd.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (lt)
                value_next = value_reg;
            else if (left_lt)
                value_next = cmd.value;
            else
                value_next = left_value;
        end
        else if (cmd.rem)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ----- dv/tb_sorted_insert_priority_queue_top.sv -----
// Self-checking testbench for sorted_insert_priority_queue_top (min-priority queue).
// Depends on spq_pkg and the RTL; runs a directed table, then biased random traffic,
// and checks every result strobe against the directed table or an in-bench sorted-queue predictor.
module tb_sorted_insert_priority_queue_top;
    import spq_pkg::*;

    localparam int unsigned CAP = 32;
    localparam int unsigned RANDOM_ITEMS = 1364;
    localparam logic signed [DATA_W-1:0] VMAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] VMIN = 32'sh80000000;

    typedef struct {
        logic signed [DATA_W-1:0] popped;
        logic                     pop_valid;
        logic signed [DATA_W-1:0] head;
        logic [5:0]               count;
        logic                     empty;
        status_t                  status;
    } queue_result_t;

    typedef struct {
        logic                     f;
        logic signed [DATA_W-1:0] v;
        int                       reps;
        bit                       typed;
        queue_result_t            res;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     func;
    logic signed [DATA_W-1:0] new_value;
    logic                     done;
    logic signed [DATA_W-1:0] popped_value;
    logic                     pop_valid;
    logic signed [DATA_W-1:0] head_value;
    logic [5:0]               entry_count;
    logic                     is_empty;
    logic [1:0]               status;

    logic signed [DATA_W-1:0] model_entries[$];
    queue_result_t            pending_results[$];
    queue_result_t            want;
    queue_result_t            no_result;
    stim_row_t                directed_rows[$];
    int                       errors = 0;

    sorted_insert_priority_queue_top #(
        .CAPACITY (CAP)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .new_value    (new_value),
        .done         (done),
        .popped_value (popped_value),
        .pop_valid    (pop_valid),
        .head_value   (head_value),
        .entry_count  (entry_count),
        .is_empty     (is_empty),
        .status       (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one transaction to the sorted model and return its result.
    function automatic queue_result_t apply_transaction(input logic f,
                                                        input logic signed [DATA_W-1:0] v);
        queue_result_t r;
        int            pos;
        r.popped    = '0;
        r.pop_valid = 1'b0;
        r.status    = STAT_OK;
        if (f == FUNC_INSERT)
        begin
            if (model_entries.size() >= CAP)
                r.status = STAT_FULL;
            else
            begin
                // place ahead of any equal entries
                pos = 0;
                while (pos < model_entries.size() && model_entries[pos] < v)
                    pos++;
                model_entries.insert(pos, v);
            end
        end
        else if (model_entries.size() == 0)
            r.status = STAT_EMPTY;
        else
        begin
            r.popped    = model_entries.pop_front();
            r.pop_valid = 1'b1;
        end
        r.head  = (model_entries.size() > 0) ? model_entries[0] : '0;
        r.count = 6'(model_entries.size());
        r.empty = (model_entries.size() == 0);
        return r;
    endfunction

    function automatic void add_row(input logic f, input logic signed [DATA_W-1:0] v,
                                    input int reps, input bit typed,
                                    input logic signed [DATA_W-1:0] popped, input logic pv,
                                    input logic signed [DATA_W-1:0] head,
                                    input logic [5:0] cnt, input logic emp,
                                    input status_t st);
        stim_row_t row;
        row.f             = f;
        row.v             = v;
        row.reps          = reps;
        row.typed         = typed;
        row.res.popped    = popped;
        row.res.pop_valid = pv;
        row.res.head      = head;
        row.res.count     = cnt;
        row.res.empty     = emp;
        row.res.status    = st;
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return VMAX;
            1: return VMIN;
            2, 3: return $signed($urandom_range(16)) - 8;  // force duplicates
            default: return $urandom;
        endcase
    endfunction

    // Issue one transaction, wait for acceptance, record its expected result.
    task automatic issue(input logic f, input logic signed [DATA_W-1:0] v, input bit quiet,
                         input bit typed, input queue_result_t typed_res);
        queue_result_t r;
        while (!quiet && $urandom_range(99) < 30)
        begin
            start     <= 1'b0;
            func      <= 1'($urandom_range(1));
            new_value <= $urandom;
            @(posedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        new_value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        r = apply_transaction(f, v);
        if (typed)
            pending_results.push_back(typed_res);
        else
            pending_results.push_back(r);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($isunknown(done))
            begin
                $display("%0t: done expected 0/1 actual %b", $time, done);
                errors++;
            end
            else if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result strobe expected none actual head %0d",
                             $time, head_value);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (popped_value !== want.popped)
                    begin
                        $display("%0t: popped_value expected %0d actual %0d",
                                 $time, want.popped, popped_value);
                        errors++;
                    end
                    if (pop_valid !== want.pop_valid)
                    begin
                        $display("%0t: pop_valid expected %b actual %b",
                                 $time, want.pop_valid, pop_valid);
                        errors++;
                    end
                    if (head_value !== want.head)
                    begin
                        $display("%0t: head_value expected %0d actual %0d",
                                 $time, want.head, head_value);
                        errors++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.count, entry_count);
                        errors++;
                    end
                    if (is_empty !== want.empty)
                    begin
                        $display("%0t: is_empty expected %b actual %b",
                                 $time, want.empty, is_empty);
                        errors++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int   i;
        int   k;
        int   bias;
        logic f;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        func      <= FUNC_INSERT;
        new_value <= '0;
        no_result.popped    = '0;
        no_result.pop_valid = 1'b0;
        no_result.head      = '0;
        no_result.count     = '0;
        no_result.empty     = 1'b0;
        no_result.status    = STAT_OK;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // f, value, repeat, typed, popped, pop_valid, head, count, empty, status
        add_row(FUNC_REMOVE, 0,    1, 1, 0,    0, 0,    0, 1, STAT_EMPTY);
        add_row(FUNC_INSERT, VMAX, 1, 1, 0,    0, VMAX, 1, 0, STAT_OK);
        add_row(FUNC_INSERT, VMIN, 1, 1, 0,    0, VMIN, 2, 0, STAT_OK);
        add_row(FUNC_INSERT, 0,    1, 1, 0,    0, VMIN, 3, 0, STAT_OK);
        add_row(FUNC_INSERT, -1,   1, 1, 0,    0, VMIN, 4, 0, STAT_OK);
        add_row(FUNC_REMOVE, 0,    1, 1, VMIN, 1, -1,   3, 0, STAT_OK);
        add_row(FUNC_REMOVE, VMAX, 1, 1, -1,   1, 0,    2, 0, STAT_OK);
        add_row(FUNC_INSERT, 0,            1, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(FUNC_INSERT, 5,            1, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(FUNC_INSERT, 32'haaaaaaaa, 1, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(FUNC_INSERT, 32'h55555555, 1, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(FUNC_REMOVE, VMIN,         6, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(FUNC_REMOVE, VMAX, 1, 1, 0,    0, 0,    0, 1, STAT_EMPTY);
        // fill with equal values, then hit the full store
        add_row(FUNC_INSERT, 7,    CAP, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(FUNC_INSERT, VMIN, 1, 1, 0,    0, 7,    32, 0, STAT_FULL);
        add_row(FUNC_REMOVE, 0,    1, 1, 7,    1, 7,    31, 0, STAT_OK);
        add_row(FUNC_INSERT, VMAX,         1, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(FUNC_REMOVE, 0,          CAP, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(FUNC_REMOVE, -1,   1, 1, 0,    0, 0,    0, 1, STAT_EMPTY);

        foreach (directed_rows[r])
            for (k = 0; k < directed_rows[r].reps; k++)
                issue(directed_rows[r].f, directed_rows[r].v, 1'b0,
                      directed_rows[r].typed && directed_rows[r].reps == 1,
                      directed_rows[r].res);

        // Alternate fill, drain and balanced phases to sweep full and empty.
        bias = 50;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                case ($urandom_range(2))
                    0: bias = 85;
                    1: bias = 15;
                    default: bias = 50;
                endcase
            f = ($urandom_range(99) < bias) ? FUNC_INSERT : FUNC_REMOVE;
            issue(f, pick_value(), (i >= 500 && i < 800), 1'b0, no_result);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule
